@@ rtl/core/ccv_pkg.sv @@
// Package for the channel correlation cost volume unit.
// Holds field widths, register codes, reset values and shared payload types.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package ccv_pkg;

    localparam int VALUE_W     = 8;
    localparam int DISP_W      = 3;
    localparam int ACC_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int COLUMNS_W     = 11;
    localparam int CHANNELS_W    = 7;
    localparam int DISPARITIES_W = 4;
    localparam int SHIFT_W       = 4;

    localparam logic [COLUMNS_W-1:0]     RESET_COLUMNS       = 11'd88;
    localparam logic [CHANNELS_W-1:0]    RESET_CHANNELS      = 7'd58;
    localparam logic [DISPARITIES_W-1:0] RESET_DISPARITIES   = 4'd5;
    localparam logic [SHIFT_W-1:0]       RESET_PRODUCT_SHIFT = 4'd6;
    localparam logic [SHIFT_W-1:0]       RESET_RESULT_SHIFT  = 4'd0;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 16'sh7FFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 16'sh8000;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [DISP_W-1:0]         disp_t;
    typedef logic [CFG_INDEX_W-1:0]    cfg_addr_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLUMNS,
        CFG_CHANNELS,
        CFG_DISPARITIES,
        CFG_PRODUCT_SHIFT,
        CFG_RESULT_SHIFT
    } cfg_index_t;

endpackage

@@ rtl/core/ccv_if.sv @@
// Handshake channels of the channel correlation cost volume unit.
// Sample input, result output and register write channels; uses ccv_pkg.
`timescale 1ns / 1ps

interface ccv_sample_if;
    logic            valid;
    logic            ready;
    ccv_pkg::value_t first_value;
    ccv_pkg::value_t second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface ccv_result_if;
    logic            valid;
    logic            ready;
    ccv_pkg::disp_t  disparity;
    ccv_pkg::value_t correlation;
    logic            last;

    modport source (output valid, output disparity, output correlation, output last,
                    input ready);
    modport sink   (input valid, input disparity, input correlation, input last,
                    output ready);
endinterface

interface ccv_cfg_if;
    logic               valid;
    logic               ready;
    ccv_pkg::cfg_addr_t index;
    ccv_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/channel_correlation_cost_volume_unit.sv @@
// Top level of the channel correlation cost volume unit.
// Depends on ccv_pkg and the channel interfaces in ccv_if.sv.
//
// Samples arrive on the samples channel row by row, pixel by pixel, channels
// innermost; each transfer carries one signed channel value of each image.
// For every disparity the first value is multiplied with the second-image value
// of the same channel from that many columns earlier, shifted and added into a
// saturating 16-bit accumulator. After the last channel of a pixel the unit
// sends one transfer per disparity on the results channel, disparity zero first,
// with last set on the final one. Registers are written on the cfg channel, which
// is always ready; the user must write them only while no pixel is in flight, as
// the unit does not enforce it. One sample is taken every cycle unless the pipeline
// holds. The second-image history lives in a memory with one row per channel, read
// at acceptance and written back as the sample leaves the b stage, with forwarding
// when the next sample hits the same row. A pixel's results are loaded into an output
// buffer once its last channel has passed the b and c stages, and leave from it at
// one per cycle while results.ready is high. When the next pixel ends while that
// buffer is still full, the pipeline holds and samples.ready drops until the buffer
// is free. So the rate stays at one sample per cycle as long as a pixel has more
// channels than disparities, and a stalled receiver stalls the input the same way.
// Reset clears counters, accumulators and registers to their defaults.
`timescale 1ns / 1ps

module channel_correlation_cost_volume_unit #(
    parameter int MAX_DISPARITIES = 8,
    parameter int MAX_CHANNELS    = 64,
    parameter int MAX_COLUMNS     = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    ccv_cfg_if.sink      cfg,
    ccv_sample_if.sink   samples,
    ccv_result_if.source results
);

    localparam int HD     = (MAX_DISPARITIES > 1) ? MAX_DISPARITIES - 1 : 1;
    localparam int HW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int DW     = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
    localparam int COLN_W = $clog2(MAX_COLUMNS + 1);
    localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
    localparam int DSN_W  = $clog2(MAX_DISPARITIES + 1);
    localparam int VW     = ccv_pkg::VALUE_W;
    localparam int AW     = ccv_pkg::ACC_W;

    logic [ccv_pkg::COLUMNS_W-1:0]     cols_reg, cols_next;
    logic [ccv_pkg::CHANNELS_W-1:0]    chans_reg, chans_next;
    logic [ccv_pkg::DISPARITIES_W-1:0] disps_reg, disps_next;
    logic [ccv_pkg::SHIFT_W-1:0]       pshift_reg, pshift_next;
    logic [ccv_pkg::SHIFT_W-1:0]       rshift_reg, rshift_next;

    logic [COLN_W-1:0] eff_cols;
    logic [CHN_W-1:0]  eff_chans;
    logic [DSN_W-1:0]  eff_disps;

    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] chan_reg, chan_next;

    logic adv;
    logic accept;
    logic pixel_end;
    logic row_end;
    logic [MAX_DISPARITIES-1:0] lane_mask;

    logic [HD-1:0][VW-1:0] hist_mem [MAX_CHANNELS];
    logic [HD-1:0][VW-1:0] hist_q;

    logic                       b_valid_reg, b_valid_next;
    logic                       fwd_sel_reg, fwd_sel_next;
    ccv_pkg::value_t            b_first_reg;
    ccv_pkg::value_t            b_second_reg;
    logic [HW-1:0]              b_ch_reg;
    logic [MAX_DISPARITIES-1:0] b_mask_reg;
    logic                       b_end_reg;
    logic [HD-1:0][VW-1:0]      fwd_row_reg;
    logic [HD-1:0][VW-1:0]      b_row;
    logic [HD-1:0][VW-1:0]      b_new_row;
    logic [MAX_DISPARITIES-1:0][AW-1:0] term_next;

    logic                               c_valid_reg, c_valid_next;
    logic [MAX_DISPARITIES-1:0][AW-1:0] c_term_reg;
    logic [MAX_DISPARITIES-1:0]         c_mask_reg;
    logic                               c_end_reg;
    logic [MAX_DISPARITIES-1:0][AW-1:0] acc_reg, acc_next;
    logic [MAX_DISPARITIES-1:0][AW-1:0] acc_upd;
    logic [MAX_DISPARITIES-1:0][VW-1:0] res_bytes;
    logic                               load;

    logic                               buf_valid_reg, buf_valid_next;
    logic [DW-1:0]                      buf_idx_reg, buf_idx_next;
    logic [DSN_W-1:0]                   buf_count_reg, buf_count_next;
    logic [MAX_DISPARITIES-1:0][VW-1:0] buf_data_reg;
    logic                               fire;
    logic                               out_last;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cols_next   = cols_reg;
        chans_next  = chans_reg;
        disps_next  = disps_reg;
        pshift_next = pshift_reg;
        rshift_next = rshift_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                ccv_pkg::CFG_COLUMNS:       cols_next   = cfg.data[ccv_pkg::COLUMNS_W-1:0];
                ccv_pkg::CFG_CHANNELS:      chans_next  = cfg.data[ccv_pkg::CHANNELS_W-1:0];
                ccv_pkg::CFG_DISPARITIES:   disps_next  = cfg.data[ccv_pkg::DISPARITIES_W-1:0];
                ccv_pkg::CFG_PRODUCT_SHIFT: pshift_next = cfg.data[ccv_pkg::SHIFT_W-1:0];
                ccv_pkg::CFG_RESULT_SHIFT:  rshift_next = cfg.data[ccv_pkg::SHIFT_W-1:0];
                default:                    cols_next   = cols_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cols_reg == '0)
            eff_cols = COLN_W'(1);
        else if (32'(cols_reg) > MAX_COLUMNS)
            eff_cols = COLN_W'(MAX_COLUMNS);
        else
            eff_cols = COLN_W'(cols_reg);

        if (chans_reg == '0)
            eff_chans = CHN_W'(1);
        else if (32'(chans_reg) > MAX_CHANNELS)
            eff_chans = CHN_W'(MAX_CHANNELS);
        else
            eff_chans = CHN_W'(chans_reg);

        if (disps_reg == '0)
            eff_disps = DSN_W'(1);
        else if (32'(disps_reg) > MAX_DISPARITIES)
            eff_disps = DSN_W'(MAX_DISPARITIES);
        else
            eff_disps = DSN_W'(disps_reg);
    end

    // The whole pipeline holds while a finished pixel waits for the output buffer.
    assign adv           = !(c_valid_reg && c_end_reg && buf_valid_reg);
    assign accept        = samples.valid && adv;
    assign samples.ready = adv;

    always_comb
    begin
        pixel_end = (32'(chan_reg) + 32'd1) >= 32'(eff_chans);
        row_end   = (32'(col_reg) + 32'd1) >= 32'(eff_cols);
        for (int d = 0; d < MAX_DISPARITIES; d++)
        begin
            lane_mask[d] = 32'(col_reg) >= 32'(d);
        end

        chan_next = chan_reg;
        col_next  = col_reg;
        if (accept)
        begin
            if (pixel_end)
            begin
                chan_next = '0;
                col_next  = row_end ? '0 : CW'(32'(col_reg) + 32'd1);
            end
            else
            begin
                chan_next = HW'(32'(chan_reg) + 32'd1);
            end
        end

        b_valid_next = adv ? accept : b_valid_reg;
        c_valid_next = adv ? b_valid_reg : c_valid_reg;
        fwd_sel_next = adv ? (accept && b_valid_reg && (chan_reg == b_ch_reg)) : fwd_sel_reg;
    end

    always_comb
    begin
        b_row        = fwd_sel_reg ? fwd_row_reg : hist_q;
        b_new_row[0] = b_second_reg;
        for (int k = 1; k < HD; k++)
        begin
            b_new_row[k] = b_row[k-1];
        end
        for (int d = 0; d < MAX_DISPARITIES; d++)
        begin
            logic signed [VW-1:0] other;
            logic signed [AW-1:0] prod;
            other        = (d == 0) ? b_second_reg : $signed(b_row[(d == 0) ? 0 : d - 1]);
            prod         = b_first_reg * other;
            term_next[d] = prod >>> pshift_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
            hist_mem[b_ch_reg] <= b_new_row;
        if (accept)
            hist_q <= hist_mem[chan_reg];
    end

    always_comb
    begin
        for (int d = 0; d < MAX_DISPARITIES; d++)
        begin
            logic signed [AW:0] sum;
            sum = {acc_reg[d][AW-1], acc_reg[d]} + {c_term_reg[d][AW-1], c_term_reg[d]};
            if (!c_mask_reg[d])
                acc_upd[d] = acc_reg[d];
            else if (sum > $signed({ccv_pkg::ACC_MAX[AW-1], ccv_pkg::ACC_MAX}))
                acc_upd[d] = ccv_pkg::ACC_MAX;
            else if (sum < $signed({ccv_pkg::ACC_MIN[AW-1], ccv_pkg::ACC_MIN}))
                acc_upd[d] = ccv_pkg::ACC_MIN;
            else
                acc_upd[d] = sum[AW-1:0];
            res_bytes[d] = VW'($signed(acc_upd[d]) >>> rshift_reg);
        end

        load = adv && c_valid_reg && c_end_reg;
        if (adv && c_valid_reg)
            acc_next = c_end_reg ? '0 : acc_upd;
        else
            acc_next = acc_reg;
    end

    always_comb
    begin
        fire     = buf_valid_reg && results.ready;
        out_last = (32'(buf_idx_reg) + 32'd1) == 32'(buf_count_reg);

        buf_valid_next = buf_valid_reg;
        buf_idx_next   = buf_idx_reg;
        buf_count_next = buf_count_reg;
        if (load)
        begin
            buf_valid_next = 1'b1;
            buf_idx_next   = '0;
            buf_count_next = eff_disps;
        end
        else if (fire)
        begin
            if (out_last)
                buf_valid_next = 1'b0;
            else
                buf_idx_next = DW'(32'(buf_idx_reg) + 32'd1);
        end
    end

    assign results.valid       = buf_valid_reg;
    assign results.disparity   = 3'(buf_idx_reg);
    assign results.correlation = buf_data_reg[buf_idx_reg];
    assign results.last        = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= ccv_pkg::RESET_COLUMNS;
            chans_reg     <= ccv_pkg::RESET_CHANNELS;
            disps_reg     <= ccv_pkg::RESET_DISPARITIES;
            pshift_reg    <= ccv_pkg::RESET_PRODUCT_SHIFT;
            rshift_reg    <= ccv_pkg::RESET_RESULT_SHIFT;
            col_reg       <= '0;
            chan_reg      <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fwd_sel_reg   <= 1'b0;
            acc_reg       <= '0;
            buf_valid_reg <= 1'b0;
            buf_idx_reg   <= '0;
            buf_count_reg <= '0;
        end
        else
        begin
            cols_reg      <= cols_next;
            chans_reg     <= chans_next;
            disps_reg     <= disps_next;
            pshift_reg    <= pshift_next;
            rshift_reg    <= rshift_next;
            col_reg       <= col_next;
            chan_reg      <= chan_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            fwd_sel_reg   <= fwd_sel_next;
            acc_reg       <= acc_next;
            buf_valid_reg <= buf_valid_next;
            buf_idx_reg   <= buf_idx_next;
            buf_count_reg <= buf_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_first_reg  <= samples.first_value;
            b_second_reg <= samples.second_value;
            b_ch_reg     <= chan_reg;
            b_mask_reg   <= lane_mask;
            b_end_reg    <= pixel_end;
        end
        if (adv)
        begin
            fwd_row_reg <= b_new_row;
            c_term_reg  <= term_next;
            c_mask_reg  <= b_mask_reg;
            c_end_reg   <= b_end_reg;
        end
        if (load)
            buf_data_reg <= res_bytes;
    end

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (acc_reg == '0))
        else $error("accumulators not cleared after a pixel ended");

    a_buf_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(buf_valid_reg) |-> $past(c_valid_reg && c_end_reg))
        else $error("output buffer filled without a finished pixel");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && out_last && !load) |=> (!buf_valid_reg || buf_idx_reg == '0))
        else $error("output buffer did not restart after the last result");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_end_reg && buf_valid_reg) |=> (c_valid_reg && $stable(c_term_reg)))
        else $error("finished pixel lost while the output buffer was full");

endmodule

@@ tb/channel_correlation_cost_volume_unit_tb.sv @@
// Self-checking testbench for the channel correlation cost volume unit.
// Drives samples and register writes, predicts every correlation result and checks it.
// Depends on ccv_pkg, the channel interfaces in ccv_if.sv and the unit's top level.
`timescale 1ns / 1ps

module channel_correlation_cost_volume_unit_tb;

    localparam int MAX_DISP      = 8;
    localparam int MAX_CHAN      = 64;
    localparam int MAX_COL       = 1024;
    localparam int HISTORY_DEPTH = MAX_DISP - 1;
    localparam int IDLE_PERCENT  = 28;
    localparam int RANDOM_ITEMS  = 72;
    localparam int SETTLE_CYCLES = 16;
    localparam int HANG_LIMIT    = 2000;

    localparam ccv_pkg::value_t    VALUE_MIN          = ccv_pkg::value_t'(-128);
    localparam ccv_pkg::value_t    VALUE_MAX          = ccv_pkg::value_t'(127);
    localparam ccv_pkg::cfg_addr_t FIRST_UNUSED_INDEX =
        ccv_pkg::cfg_addr_t'(ccv_pkg::CFG_RESULT_SHIFT) + ccv_pkg::cfg_addr_t'(1);

    typedef struct {
        ccv_pkg::disp_t  disparity;
        ccv_pkg::value_t correlation;
        logic            last;
    } cost_t;

    logic clk;
    logic rst_n;

    ccv_cfg_if    cfg_bus ();
    ccv_sample_if sample_bus ();
    ccv_result_if result_bus ();

    channel_correlation_cost_volume_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (sample_bus),
        .results (result_bus)
    );

    logic [ccv_pkg::COLUMNS_W-1:0]     columns_reg;
    logic [ccv_pkg::CHANNELS_W-1:0]    channels_reg;
    logic [ccv_pkg::DISPARITIES_W-1:0] disparities_reg;
    logic [ccv_pkg::SHIFT_W-1:0]       product_shift_reg;
    logic [ccv_pkg::SHIFT_W-1:0]       result_shift_reg;

    ccv_pkg::value_t past_second [MAX_CHAN][HISTORY_DEPTH];
    int              past_fill [MAX_CHAN];
    int              partial_sum [MAX_DISP];
    int              column_pos;
    int              channel_pos;

    cost_t expected_costs [$];
    int    error_count;
    bit    steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_range(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int channels_now();
        return clamp_range(channels_reg, 1, MAX_CHAN);
    endfunction

    // Widest channel count whose history entries are all written for the current column.
    function automatic int safe_channel_limit();
        int need;
        int n;
        need = (column_pos < HISTORY_DEPTH) ? column_pos : HISTORY_DEPTH;
        n = 0;
        while (n < MAX_CHAN && past_fill[n] >= need)
            n++;
        return n;
    endfunction

    function automatic void apply_register(input ccv_pkg::cfg_addr_t idx,
                                           input ccv_pkg::cfg_data_t data);
        case (idx)
            ccv_pkg::CFG_COLUMNS:       columns_reg       = data[ccv_pkg::COLUMNS_W-1:0];
            ccv_pkg::CFG_CHANNELS:      channels_reg      = data[ccv_pkg::CHANNELS_W-1:0];
            ccv_pkg::CFG_DISPARITIES:   disparities_reg   = data[ccv_pkg::DISPARITIES_W-1:0];
            ccv_pkg::CFG_PRODUCT_SHIFT: product_shift_reg = data[ccv_pkg::SHIFT_W-1:0];
            ccv_pkg::CFG_RESULT_SHIFT:  result_shift_reg  = data[ccv_pkg::SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void accumulate_sample(input ccv_pkg::value_t first_val,
                                              input ccv_pkg::value_t second_val);
        int    columns;
        int    disparities;
        int    ch;
        int    d;
        int    k;
        int    other;
        int    total;
        cost_t cost;
        columns     = clamp_range(columns_reg, 1, MAX_COL);
        disparities = clamp_range(disparities_reg, 1, MAX_DISP);
        ch          = channel_pos % MAX_CHAN;
        for (d = 0; d < MAX_DISP; d++)
        begin
            if (column_pos >= d)
            begin
                other = (d == 0) ? int'(second_val) : int'(past_second[ch][d-1]);
                total = partial_sum[d] + ((int'(first_val) * other) >>> product_shift_reg);
                if (total > int'(ccv_pkg::ACC_MAX))
                    total = int'(ccv_pkg::ACC_MAX);
                if (total < int'(ccv_pkg::ACC_MIN))
                    total = int'(ccv_pkg::ACC_MIN);
                partial_sum[d] = total;
            end
        end
        for (k = HISTORY_DEPTH - 1; k > 0; k--)
            past_second[ch][k] = past_second[ch][k-1];
        past_second[ch][0] = second_val;
        if (past_fill[ch] < HISTORY_DEPTH)
            past_fill[ch]++;
        if (channel_pos + 1 >= channels_now())
        begin
            for (d = 0; d < disparities; d++)
            begin
                cost.disparity   = ccv_pkg::disp_t'(d);
                cost.correlation = ccv_pkg::value_t'(partial_sum[d] >>> result_shift_reg);
                cost.last        = (d + 1 == disparities);
                expected_costs.push_back(cost);
            end
            for (d = 0; d < MAX_DISP; d++)
                partial_sum[d] = 0;
            channel_pos = 0;
            column_pos  = (column_pos + 1 >= columns) ? 0 : column_pos + 1;
        end
        else
            channel_pos++;
    endfunction

    function automatic ccv_pkg::cfg_data_t with_noise(input int value, input int width);
        return (ccv_pkg::cfg_data_t'($urandom) << width) | ccv_pkg::cfg_data_t'(value);
    endfunction

    function automatic ccv_pkg::value_t pick_value();
        case ($urandom_range(7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return ccv_pkg::value_t'(0);
            default: return ccv_pkg::value_t'($urandom);
        endcase
    endfunction

    // Leaves valid high so that back-to-back writes need no gap; the caller lowers it.
    task automatic write_register(input ccv_pkg::cfg_addr_t idx,
                                  input ccv_pkg::cfg_data_t data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        apply_register(idx, data);
    endtask

    task automatic configure(input int columns, input int channels, input int disparities,
                             input int product_shift, input int result_shift,
                             input bit touch_unused);
        int limit;
        int i;
        limit = safe_channel_limit();
        if (clamp_range(channels % (1 << ccv_pkg::CHANNELS_W), 1, MAX_CHAN) > limit)
            channels = limit;
        write_register(ccv_pkg::CFG_COLUMNS, with_noise(columns, ccv_pkg::COLUMNS_W));
        write_register(ccv_pkg::CFG_CHANNELS, with_noise(channels, ccv_pkg::CHANNELS_W));
        write_register(ccv_pkg::CFG_DISPARITIES,
                       with_noise(disparities, ccv_pkg::DISPARITIES_W));
        write_register(ccv_pkg::CFG_PRODUCT_SHIFT, with_noise(product_shift, ccv_pkg::SHIFT_W));
        write_register(ccv_pkg::CFG_RESULT_SHIFT, with_noise(result_shift, ccv_pkg::SHIFT_W));
        if (touch_unused)
            for (i = int'(FIRST_UNUSED_INDEX); i < (1 << ccv_pkg::CFG_INDEX_W); i++)
                write_register(ccv_pkg::cfg_addr_t'(i), ccv_pkg::cfg_data_t'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_sample(input ccv_pkg::value_t first_val,
                               input ccv_pkg::value_t second_val);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.first_value  <= first_val;
        sample_bus.second_value <= second_val;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        accumulate_sample(first_val, second_val);
    endtask

    task automatic drain_costs();
        sample_bus.valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        int k;
        for (k = 0; k < channels_now(); k++)
            send_sample(pick_value(), pick_value());
        drain_costs();
    endtask

    task automatic test_saturation();
        int k;
        configure(MAX_COL, 3, MAX_DISP, 0, 0, 1'b0);
        for (k = 0; k < 3; k++)
            send_sample(VALUE_MIN, VALUE_MIN);
        for (k = 0; k < 3; k++)
            send_sample(VALUE_MAX, VALUE_MIN);
        drain_costs();
    endtask

    task automatic test_shift_extremes();
        configure(MAX_COL, 1, MAX_DISP, 15, 15, 1'b0);
        send_sample(VALUE_MAX, VALUE_MAX);
        send_sample(ccv_pkg::value_t'(-1), ccv_pkg::value_t'(1));
        send_sample(VALUE_MIN, VALUE_MAX);
        send_sample(ccv_pkg::value_t'(0), VALUE_MIN);
        drain_costs();
    endtask

    task automatic test_register_saturation();
        configure(0, 0, 0, 0, 15, 1'b0);
        send_sample(VALUE_MIN, VALUE_MAX);
        drain_costs();
        configure((1 << ccv_pkg::COLUMNS_W) - 1, 1, (1 << ccv_pkg::DISPARITIES_W) - 1,
                  15, 0, 1'b0);
        send_sample(VALUE_MAX, VALUE_MIN);
        send_sample(VALUE_MIN, VALUE_MIN);
        drain_costs();
    endtask

    task automatic test_unused_registers();
        configure(5, 2, 4, 3, 2, 1'b1);
        send_sample(VALUE_MAX, ccv_pkg::value_t'(-77));
        send_sample(ccv_pkg::value_t'(-3), VALUE_MAX);
        drain_costs();
    endtask

    task automatic test_row_wrap();
        int k;
        configure(9, 1, MAX_DISP, 2, 1, 1'b0);
        for (k = 0; k < 10; k++)
            send_sample(k[0] ? VALUE_MIN : VALUE_MAX, k[1] ? VALUE_MAX : VALUE_MIN);
        drain_costs();
    endtask

    // Mostly small pixels and short rows so that every disparity and row wrap is
    // reached often; now and then a phase uses a channel setting of 48 or more.
    task automatic test_random_streams();
        int sent;
        int phase;
        int columns;
        int channels;
        int pixels;
        int n;
        int k;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (phase < 2);
            case ($urandom_range(9))
                0:       columns = 1;
                1:       columns = MAX_COL;
                2:       columns = $urandom_range((1 << ccv_pkg::COLUMNS_W) - 1, MAX_COL + 1);
                3:       columns = 0;
                default: columns = $urandom_range(12, 2);
            endcase
            channels = ($urandom_range(9) == 0)
                       ? $urandom_range((1 << ccv_pkg::CHANNELS_W) - 1, 48)
                       : $urandom_range(8, 0);
            configure(columns, channels, $urandom_range((1 << ccv_pkg::DISPARITIES_W) - 1),
                      $urandom_range(15), $urandom_range(15), phase == 1);
            pixels = (channels_now() > 16) ? $urandom_range(2, 1) : $urandom_range(12, 3);
            for (n = 0; n < pixels && sent < RANDOM_ITEMS; n++)
                for (k = 0; k < channels_now(); k++)
                begin
                    send_sample(pick_value(), pick_value());
                    sent++;
                end
            drain_costs();
            phase++;
        end
        steady = 1'b0;
    endtask

    initial
    begin : result_checker
        cost_t want;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_costs.size() == 0)
                begin
                    error_count++;
                    $error("results: unexpected transfer, disparity %0d correlation %0d",
                           result_bus.disparity, result_bus.correlation);
                end
                else
                begin
                    want = expected_costs.pop_front();
                    if (result_bus.disparity !== want.disparity)
                    begin
                        error_count++;
                        $error("disparity: expected %0d, got %0d",
                               want.disparity, result_bus.disparity);
                    end
                    if (result_bus.correlation !== want.correlation)
                    begin
                        error_count++;
                        $error("correlation: expected %0d, got %0d",
                               want.correlation, result_bus.correlation);
                    end
                    if (result_bus.last !== want.last)
                    begin
                        error_count++;
                        $error("last: expected %0b, got %0b", want.last, result_bus.last);
                    end
                end
            end
            result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : hang_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_bus.valid && sample_bus.ready)
                    || (result_bus.valid && result_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int ch;
        int k;
        error_count = 0;
        steady      = 1'b0;
        rst_n                   <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= '0;
        cfg_bus.data            <= '0;
        sample_bus.valid        <= 1'b0;
        sample_bus.first_value  <= '0;
        sample_bus.second_value <= '0;
        columns_reg       = ccv_pkg::RESET_COLUMNS;
        channels_reg      = ccv_pkg::RESET_CHANNELS;
        disparities_reg   = ccv_pkg::RESET_DISPARITIES;
        product_shift_reg = ccv_pkg::RESET_PRODUCT_SHIFT;
        result_shift_reg  = ccv_pkg::RESET_RESULT_SHIFT;
        for (ch = 0; ch < MAX_CHAN; ch++)
        begin
            past_fill[ch] = 0;
            for (k = 0; k < HISTORY_DEPTH; k++)
                past_second[ch][k] = '0;
        end
        for (k = 0; k < MAX_DISP; k++)
            partial_sum[k] = 0;
        column_pos  = 0;
        channel_pos = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_saturation();
        test_shift_extremes();
        test_register_saturation();
        test_unused_registers();
        test_row_wrap();
        test_random_streams();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ channel_correlation_cost_volume_unit.f @@
rtl/core/ccv_pkg.sv
rtl/core/ccv_if.sv
rtl/core/channel_correlation_cost_volume_unit.sv
tb/channel_correlation_cost_volume_unit_tb.sv
